// File: hw/rtl/swkd_pkg.sv
// Shared constants and types for the key-delete stack.
`timescale 1ns / 1ps

package swkd_pkg;

    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KEY_W  = 32;
    localparam int DATA_W = 64;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_PEEK   = 2'd2;
    localparam logic [1:0] CMD_DELETE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] payload;
        logic [CNT_W-1:0]  fill;
    } t_result;

endpackage

// File: hw/rtl/swkd_mem.sv
// Entry storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module swkd_mem (
    input  logic              i_clk,
    input  swkd_pkg::t_mem_req i_req,
    output swkd_pkg::t_entry   o_rd_entry
);
    import swkd_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rd_entry = r_rdata;

endmodule

// File: hw/rtl/swkd_seq.sv
// Command sequencer: push, pop, peek and the compacting delete scan.
`timescale 1ns / 1ps

module swkd_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [1:0]                i_cmd,
    input  logic [swkd_pkg::KEY_W-1:0]  i_key,
    input  logic [swkd_pkg::DATA_W-1:0] i_payload,
    output logic                      o_res_valid,
    output swkd_pkg::t_result         o_res,
    input  logic                      i_res_ready,
    output swkd_pkg::t_mem_req        o_mem_req,
    input  swkd_pkg::t_entry          i_rd_entry
);
    import swkd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DONE
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_occ, n_occ;
    logic [CNT_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_wr, n_wr;
    logic             r_hit, n_hit;
    logic [KEY_W-1:0] r_key, n_key;
    t_result          r_res, n_res;
    logic             match;

    // The one comparator, reused on every scanned entry.
    assign match = (i_rd_entry.key == r_key);

    always_comb begin
        n_state   = r_state;
        n_occ     = r_occ;
        n_rd      = r_rd;
        n_wr      = r_wr;
        n_hit     = r_hit;
        n_key     = r_key;
        n_res     = r_res;
        o_mem_req = '{we: 1'b0, waddr: '0, wdata: '{key: i_key, data: i_payload},
                      re: 1'b0, raddr: '0};

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_cmd) inside
                        CMD_PUSH: begin
                            if (r_occ == CNT_W'(DEPTH)) begin
                                n_res = '{status: ST_FULL, key: '0, payload: '0, fill: r_occ};
                            end else begin
                                o_mem_req.we    = 1'b1;
                                o_mem_req.waddr = r_occ[ADDR_W-1:0];
                                n_occ           = r_occ + 1'b1;
                                n_res = '{status: ST_OK, key: '0, payload: '0, fill: n_occ};
                            end
                            n_state = S_DONE;
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (r_occ == '0) begin
                                n_res = '{status: ST_EMPTY, key: '0, payload: '0, fill: r_occ};
                                n_state = S_DONE;
                            end else begin
                                o_mem_req.re    = 1'b1;
                                o_mem_req.raddr = ADDR_W'(r_occ - 1'b1);
                                if (i_cmd == CMD_POP) begin
                                    n_occ = r_occ - 1'b1;
                                end
                                n_state = S_READ;
                            end
                        end
                        CMD_DELETE: begin
                            n_key = i_key;
                            if (r_occ == '0) begin
                                n_res = '{status: ST_NOTFOUND, key: '0, payload: '0,
                                          fill: r_occ};
                                n_state = S_DONE;
                            end else begin
                                o_mem_req.re    = 1'b1;
                                o_mem_req.raddr = '0;
                                n_rd    = CNT_W'(1);
                                n_wr    = '0;
                                n_hit   = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: begin
                n_res = '{status: ST_OK, key: i_rd_entry.key, payload: i_rd_entry.data,
                          fill: r_occ};
                n_state = S_DONE;
            end
            S_SCAN: begin
                // Keep non-matching entries, packed down toward the bottom.
                if (match) begin
                    n_hit = 1'b1;
                end else begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = r_wr[ADDR_W-1:0];
                    o_mem_req.wdata = i_rd_entry;
                    n_wr            = r_wr + 1'b1;
                end
                if (r_rd == r_occ) begin
                    n_occ   = n_wr;
                    n_res   = '{status: n_hit ? ST_OK : ST_NOTFOUND, key: '0, payload: '0,
                                fill: n_wr};
                    n_state = S_DONE;
                end else begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = r_rd[ADDR_W-1:0];
                    n_rd            = r_rd + 1'b1;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_rd    <= '0;
            r_wr    <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_hit   <= n_hit;
        end
        r_key <= n_key;
        r_res <= n_res;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

// File: hw/rtl/stack_with_key_delete_core.sv
// Top level of the LIFO stack with delete-by-key.
`timescale 1ns / 1ps

// LIFO stack of DEPTH (16) entries, each a 32-bit key and a 64-bit payload,
// with one result per command: status, popped or peeked entry, fill level.
// A push is handled in the idle state; pop and peek also pass through
// a read state (the entry store has a registered read port). Delete-by-key
// reads the stored entries one per cycle through the single store read port
// and compares each against the key; matches are dropped and the rest are
// packed down in order. Every result is registered in the sequencer's done
// state and handed from there to the output register; no new command is
// accepted until it is. The input is not ready while a command is in work.
// A finished result sits in an output register, so the next command can be
// accepted while it waits; a second result waits inside the sequencer.
// After reset the stack is empty and no clearing pass is needed.
module stack_with_key_delete_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_cmd,
    input  logic [swkd_pkg::KEY_W-1:0]  i_key,
    input  logic [swkd_pkg::DATA_W-1:0] i_payload,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_status,
    output logic [swkd_pkg::KEY_W-1:0]  o_out_key,
    output logic [swkd_pkg::DATA_W-1:0] o_out_payload,
    output logic [swkd_pkg::CNT_W-1:0]  o_fill_level
);
    import swkd_pkg::*;

    t_mem_req mem_req;
    t_entry   rd_entry;
    t_result  res;
    logic     res_valid;
    logic     res_ready;

    logic     r_ovalid;
    t_result  r_out;

    swkd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_key       (i_key),
        .i_payload   (i_payload),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_mem_req   (mem_req),
        .i_rd_entry  (rd_entry)
    );

    swkd_mem u_mem (
        .i_clk      (i_clk),
        .i_req      (mem_req),
        .o_rd_entry (rd_entry)
    );

    // Load the output register when it is empty or being drained.
    assign res_ready = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_out.status;
    assign o_out_key     = r_out.key;
    assign o_out_payload = r_out.payload;
    assign o_fill_level  = r_out.fill;

endmodule
